/* design/mrbf_pkg.sv */
// Package for the multi-reader broadcast FIFO: types, codes and default sizes.
`timescale 1ns / 1ps
`default_nettype none
package mrbf_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int READERS_DEF  = 2;
    localparam int MSG_BITS_DEF = 64;
    localparam int MSG_W        = 64;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_DATA = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        t_status status;
        logic    read_ok;
    } t_ctrl_res;

endpackage
`default_nettype wire

/* design/mrbf_ifs.sv */
// Valid/ready channel interfaces for requests and results of the broadcast FIFO.
`timescale 1ns / 1ps
`default_nettype none
interface mrbf_req_if;
    logic                          valid;
    logic                          ready;
    mrbf_pkg::t_opcode             opcode;
    logic                          reader_id;
    logic [mrbf_pkg::MSG_W-1:0]    message_in;

    modport source (output valid, output opcode, output reader_id, output message_in,
                    input ready);
    modport sink   (input valid, input opcode, input reader_id, input message_in,
                    output ready);
endinterface

interface mrbf_res_if;
    logic                          valid;
    logic                          ready;
    mrbf_pkg::t_status             status;
    logic [mrbf_pkg::MSG_W-1:0]    message_out;

    modport source (output valid, output status, output message_out, input ready);
    modport sink   (input valid, input status, input message_out, output ready);
endinterface
`default_nettype wire

/* design/mrbf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mrbf_ram #(
    parameter int W = 64,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [$clog2(D)-1:0] i_wr_addr,
    input  wire logic [W-1:0]         i_wr_data,
    input  wire logic                 i_rd_en,
    input  wire logic [$clog2(D)-1:0] i_rd_addr,
    output logic      [W-1:0]         o_rd_data
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

/* design/mrbf_ctrl.sv */
// Pointer state and per-transaction decisions: tail, oldest and reader pointers.
`timescale 1ns / 1ps
`default_nettype none
module mrbf_ctrl #(
    parameter int DEPTH    = mrbf_pkg::DEPTH_DEF,
    parameter int READERS  = mrbf_pkg::READERS_DEF,
    parameter int MSG_BITS = mrbf_pkg::MSG_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire mrbf_pkg::t_opcode          i_opcode,
    input  wire logic                       i_reader_id,
    input  wire logic [mrbf_pkg::MSG_W-1:0] i_message_in,
    output mrbf_pkg::t_ctrl_res             o_res,
    output logic                            o_wr_en,
    output logic [$clog2(DEPTH)-1:0]        o_wr_addr,
    output logic [MSG_BITS-1:0]             o_wr_data,
    output logic                            o_rd_en,
    output logic [$clog2(DEPTH)-1:0]        o_rd_addr
);

    localparam int PW = $clog2(2 * DEPTH);
    localparam int AW = $clog2(DEPTH);
    localparam logic [PW-1:0] LAST_POS = PW'(2 * DEPTH - 1);

    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_op, n_op;
    logic [PW-1:0] r_rp [READERS];
    logic [PW-1:0] n_rp [READERS];

    logic [PW:0]   held;
    logic          full;
    logic          rid_ok;
    logic [PW-1:0] sel_rp;
    logic          read_ok;
    logic          all_read;

    function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
        return (p == LAST_POS) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_of(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = (p >= PW'(DEPTH)) ? p - PW'(DEPTH) : p;
        return s[AW-1:0];
    endfunction

    always_comb begin
        held = ({1'b0, r_wp} >= {1'b0, r_op})
             ? {1'b0, r_wp} - {1'b0, r_op}
             : {1'b0, r_wp} + (PW+1)'(2 * DEPTH) - {1'b0, r_op};
        full   = held >= (PW+1)'(DEPTH);
        rid_ok = int'(i_reader_id) < READERS;

        sel_rp = '0;
        for (int r = 0; r < READERS; r++) begin
            if (int'(i_reader_id) == r) begin
                sel_rp = r_rp[r];
            end
        end

        read_ok = (i_opcode == mrbf_pkg::OP_READ) && rid_ok && (sel_rp != r_wp);

        n_wp = r_wp;
        n_op = r_op;
        for (int r = 0; r < READERS; r++) begin
            n_rp[r] = r_rp[r];
        end

        if (i_accept && i_opcode == mrbf_pkg::OP_INSERT && !full) begin
            n_wp = next_pos(r_wp);
        end

        all_read = 1'b1;
        for (int r = 0; r < READERS; r++) begin
            if (i_accept && read_ok && int'(i_reader_id) == r) begin
                n_rp[r] = next_pos(r_rp[r]);
            end
            if (n_rp[r] == r_op) begin
                all_read = 1'b0;
            end
        end
        if (i_accept && read_ok && all_read && held != '0) begin
            n_op = next_pos(r_op);
        end

        if (i_opcode == mrbf_pkg::OP_INSERT) begin
            o_res.status = full ? mrbf_pkg::ST_FULL : mrbf_pkg::ST_OK;
        end else begin
            o_res.status = read_ok ? mrbf_pkg::ST_OK : mrbf_pkg::ST_NO_DATA;
        end
        o_res.read_ok = read_ok;

        o_wr_en   = i_accept && i_opcode == mrbf_pkg::OP_INSERT && !full;
        o_wr_addr = slot_of(r_wp);
        o_wr_data = i_message_in[MSG_BITS-1:0];
        o_rd_en   = i_accept && read_ok;
        o_rd_addr = slot_of(sel_rp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_op <= '0;
            for (int r = 0; r < READERS; r++) begin
                r_rp[r] <= '0;
            end
        end else begin
            r_wp <= n_wp;
            r_op <= n_op;
            for (int r = 0; r < READERS; r++) begin
                r_rp[r] <= n_rp[r];
            end
        end
    end

endmodule
`default_nettype wire

/* design/multi_reader_broadcast_fifo_top.sv */
// Top level of the multi-reader broadcast FIFO.
//
// A ring of DEPTH message words in a synchronous RAM, shared by READERS readers, each with
// its own read pointer; an entry is freed once every reader has read it. One transaction
// (insert or read) is accepted per cycle while results are taken. The pointer decision and
// the RAM access come first, filling the stage-1 result register and the registered RAM read;
// the result then moves into an output register. Throughput is one transaction per cycle
// while results are taken; no clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module multi_reader_broadcast_fifo_top #(
    parameter int DEPTH    = mrbf_pkg::DEPTH_DEF,
    parameter int READERS  = mrbf_pkg::READERS_DEF,
    parameter int MSG_BITS = mrbf_pkg::MSG_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    mrbf_req_if.sink     i_req,
    mrbf_res_if.source   o_res
);

    localparam int AW = $clog2(DEPTH);

    mrbf_pkg::t_ctrl_res        ctrl_res;
    logic                       accept;
    logic                       s1_move;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [MSG_BITS-1:0]        wr_data;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [MSG_BITS-1:0]        rd_data;

    logic                       r_s1_vld;
    mrbf_pkg::t_ctrl_res        r_s1_res;
    logic                       r_out_vld;
    mrbf_pkg::t_status          r_out_status;
    logic [mrbf_pkg::MSG_W-1:0] r_out_msg;

    assign s1_move     = r_s1_vld && (!r_out_vld || o_res.ready);
    assign i_req.ready = !r_s1_vld || s1_move;
    assign accept      = i_req.valid && i_req.ready;

    mrbf_ctrl #(
        .DEPTH    (DEPTH),
        .READERS  (READERS),
        .MSG_BITS (MSG_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_opcode     (i_req.opcode),
        .i_reader_id  (i_req.reader_id),
        .i_message_in (i_req.message_in),
        .o_res        (ctrl_res),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr)
    );

    mrbf_ram #(
        .W (MSG_BITS),
        .D (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res <= ctrl_res;
        end
        if (s1_move) begin
            r_out_status <= r_s1_res.status;
            r_out_msg    <= r_s1_res.read_ok ? mrbf_pkg::MSG_W'(rd_data) : '0;
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.status      = r_out_status;
    assign o_res.message_out = r_out_msg;

endmodule
`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the multi-reader broadcast FIFO top level.
`timescale 1ns / 1ps
module tb;
    import mrbf_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int READERS    = READERS_DEF;
    localparam int MSG_BITS   = MSG_BITS_DEF;
    localparam int PTR_W      = $clog2(DEPTH) + 1;
    localparam int STALL_PCT  = 24;
    localparam int STALL_LIMIT = 2000;
    localparam logic [MSG_W-1:0] MSG_MASK = {MSG_W{1'b1}} >> (MSG_W - MSG_BITS);

    typedef struct {
        t_status          status;
        logic [MSG_W-1:0] message;
    } t_reply;

    logic i_clk;
    logic i_rst_n;

    mrbf_req_if req ();
    mrbf_res_if res ();

    multi_reader_broadcast_fifo_top #(
        .DEPTH   (DEPTH),
        .READERS (READERS),
        .MSG_BITS(MSG_BITS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_res  (res)
    );

    // Shadow of the ring and its pointers
    logic [MSG_W-1:0] ring_words [DEPTH];
    logic [PTR_W-1:0] tail_pos;
    logic [PTR_W-1:0] oldest_pos;
    logic [PTR_W-1:0] reader_pos [READERS];

    t_reply owed_replies[$];

    int  mismatches;
    int  idle_cycles;
    bit  no_stall;
    int  n_insert_ok, n_insert_full, n_read_ok, n_read_empty, n_replies;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        res.ready <= no_stall || ($urandom_range(0, 99) >= STALL_PCT);
    end

    task automatic predict_fifo_op(input t_opcode op, input logic rid,
                                   input logic [MSG_W-1:0] msg);
        t_reply            r;
        logic [PTR_W-1:0]  held;
        bit                oldest_pinned;
        r.status  = ST_OK;
        r.message = '0;
        held      = tail_pos - oldest_pos;
        if (op == OP_INSERT) begin
            if (held >= PTR_W'(DEPTH)) begin
                r.status = ST_FULL;
                n_insert_full++;
            end else begin
                ring_words[tail_pos[PTR_W-2:0]] = msg & MSG_MASK;
                tail_pos = tail_pos + 1'b1;
                n_insert_ok++;
            end
        end else if (int'(rid) >= READERS || reader_pos[rid] == tail_pos) begin
            r.status = ST_NO_DATA;
            n_read_empty++;
        end else begin
            r.message       = ring_words[reader_pos[rid][PTR_W-2:0]];
            reader_pos[rid] = reader_pos[rid] + 1'b1;
            oldest_pinned   = 1'b0;
            for (int k = 0; k < READERS; k++) begin
                if (reader_pos[k] == oldest_pos) oldest_pinned = 1'b1;
            end
            if (!oldest_pinned && tail_pos != oldest_pos) oldest_pos = oldest_pos + 1'b1;
            n_read_ok++;
        end
        owed_replies.push_back(r);
    endtask

    task automatic check_reply(input t_status got_status, input logic [MSG_W-1:0] got_msg);
        t_reply e;
        n_replies++;
        if (owed_replies.size() == 0) begin
            $error("unexpected result: status %0d message %h", got_status, got_msg);
            mismatches++;
        end else begin
            e = owed_replies.pop_front();
            if (got_status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, got_status);
                mismatches++;
            end
            if (got_msg !== e.message) begin
                $error("message_out: expected %h, got %h", e.message, got_msg);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) check_reply(res.status, res.message_out);
    end

    // Watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (res.valid && res.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Called and returns at a falling edge
    task automatic send_op(input t_opcode op, input logic rid, input logic [MSG_W-1:0] msg);
        while (!no_stall && $urandom_range(0, 99) < STALL_PCT) begin
            req.valid <= 1'b0;
            @(negedge i_clk);
        end
        req.valid      <= 1'b1;
        req.opcode     <= op;
        req.reader_id  <= rid;
        req.message_in <= msg;
        do @(posedge i_clk); while (!req.ready);
        predict_fifo_op(op, rid, msg);
        @(negedge i_clk);
    endtask

    task automatic wait_all_replies();
        req.valid <= 1'b0;
        while (owed_replies.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [MSG_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic test_empty_reads();
        send_op(OP_READ, 1'b0, rand_word());
        send_op(OP_READ, 1'b1, rand_word());
    endtask

    task automatic test_fill_and_overflow();
        send_op(OP_INSERT, 1'b0, {MSG_W{1'b1}});
        send_op(OP_INSERT, 1'b1, '0);
        send_op(OP_INSERT, 1'b0, {(MSG_W/2){2'b10}});
        send_op(OP_INSERT, 1'b1, {(MSG_W/2){2'b01}});
        send_op(OP_INSERT, 1'b0, {1'b1, {(MSG_W-2){1'b0}}, 1'b1});
        for (int k = 5; k < DEPTH; k++) send_op(OP_INSERT, k[0], rand_word());
        send_op(OP_INSERT, 1'b1, rand_word());
    endtask

    // Oldest entry is freed only after both readers have taken it
    task automatic test_entry_freeing();
        send_op(OP_READ, 1'b0, '0);
        send_op(OP_READ, 1'b0, {MSG_W{1'b1}});
        send_op(OP_READ, 1'b1, rand_word());
        send_op(OP_INSERT, 1'b0, rand_word());
        send_op(OP_INSERT, 1'b1, rand_word());
    endtask

    task automatic run_traffic(input int n, input int insert_pct, input int reader1_pct);
        t_opcode op;
        for (int k = 0; k < n; k++) begin
            op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_READ;
            send_op(op, logic'($urandom_range(0, 99) < reader1_pct), rand_word());
        end
    endtask

    task automatic test_random_traffic();
        run_traffic(50, 85, 50);
        run_traffic(50, 80, 0);     // reader 1 lags, ring fills
        run_traffic(50, 30, 100);
        wait_all_replies();
        no_stall = 1'b1;
        run_traffic(50, 50, 50);
        no_stall = 1'b0;
        run_traffic(50, 15, 50);    // drains, readers run dry
        run_traffic(50, 70, 20);
        run_traffic(50, 50, 50);
        run_traffic(50, 40, 80);
        wait_all_replies();
        run_traffic(50, 90, 50);
        run_traffic(50, 10, 50);
        run_traffic(50, 55, 50);
        run_traffic(50, 50, 50);
        run_traffic(50, 45, 50);
    endtask

    initial begin
        mismatches    = 0;
        idle_cycles   = 0;
        no_stall      = 1'b0;
        n_insert_ok   = 0;
        n_insert_full = 0;
        n_read_ok     = 0;
        n_read_empty  = 0;
        n_replies     = 0;
        tail_pos      = '0;
        oldest_pos    = '0;
        for (int k = 0; k < READERS; k++) reader_pos[k] = '0;
        i_rst_n        = 1'b0;
        req.valid      = 1'b0;
        req.opcode     = OP_INSERT;
        req.reader_id  = 1'b0;
        req.message_in = '0;
        res.ready      = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_reads();
        test_fill_and_overflow();
        test_entry_freeing();
        test_random_traffic();

        wait_all_replies();
        repeat (6) @(posedge i_clk);

        $display("Covered %0d inserts (%0d refused as full) and %0d reads (%0d found nothing)",
                 n_insert_ok + n_insert_full, n_insert_full,
                 n_read_ok + n_read_empty, n_read_empty);
        $display("%0d results checked, %0d mismatches", n_replies, mismatches);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
